// File: rtl/progressive_pixel_accumulator_core_assert.svh
// Assertion macros for the checker file of the pixel accumulator.
`ifndef PROGRESSIVE_PIXEL_ACCUMULATOR_CORE_ASSERT_SVH
`define PROGRESSIVE_PIXEL_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel accumulator assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel accumulator assertion failed");

`endif

// File: rtl/ppa_pkg.sv
// Shared constants, codes and types of the progressive pixel accumulator.
package ppa_pkg;

  // Store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and register widths
  localparam int POS_W     = 8;
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int DIM_W     = 9;
  localparam int IDX_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;

  // Divider sizing: C = count * 2^FRAC_BITS, numerator up to 510*S + C
  localparam int FRAC_BITS = 12;
  localparam int C_W       = CNT_W + FRAC_BITS;
  localparam int DEN_W     = C_W + 1;
  localparam int NUM_W     = C_W + 10;
  localparam int QUO_W     = BYTE_W;
  localparam int STEP_W    = $clog2(QUO_W);

  // Operation codes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT       = 2'd2;

  // Byte saturation value
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/progressive_pixel_accumulator_core.sv
// Progressive pixel accumulator: per-pixel RGB sum store with display readout.
//
// Input channel (in_valid / in_stall): one item carries an op, a pixel
// position and a signed Q3.12 RGB sample. Accumulate adds the sample to the
// pixel's saturating 32-bit sums, set overwrites them, clear zeroes the store.
// Result channel (out_valid / out_stall): accumulate and set on a pixel
// inside the image give one item with the row-flipped index and three bytes.
// Configuration (cfg_valid / cfg_ready, always ready): sample count, width
// and height; the user must write them only while the block is idle, which
// the block itself does not enforce. An item runs read, update, then per
// channel either a saturation path or a divide on the single shared 8-step
// divider; no new item is taken until it leaves the done state. Out-of-image
// items and unused ops are dropped while idle. Reset and clear both sweep all
// 65536 store entries one entry a cycle, with in_stall high. A stalled result
// holds; the next item is still accepted and runs up to the result stage,
// where it waits for the output register.
module progressive_pixel_accumulator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [ppa_pkg::POS_W-1:0]     in_pos_x,
  input  logic [ppa_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [ppa_pkg::SAMPLE_W-1:0] in_red_in,
  input  logic signed [ppa_pkg::SAMPLE_W-1:0] in_green_in,
  input  logic signed [ppa_pkg::SAMPLE_W-1:0] in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ppa_pkg::IDX_W-1:0]     out_pixel_index,
  output logic [ppa_pkg::BYTE_W-1:0]    out_red_byte,
  output logic [ppa_pkg::BYTE_W-1:0]    out_green_byte,
  output logic [ppa_pkg::BYTE_W-1:0]    out_blue_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppa_pkg::CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_UPD   = 7'b0001000,
    ST_PREP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam int MEM_W = ppa_pkg::NUM_CH * ppa_pkg::SUM_W;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [ppa_pkg::CNT_W-1:0] sample_count_r;
  logic [ppa_pkg::DIM_W-1:0] width_r;
  logic [ppa_pkg::DIM_W-1:0] height_r;

  // Sequencer registers
  logic [ppa_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ppa_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Item payload registers
  logic [1:0]                    op_r;
  logic [ppa_pkg::POS_W-1:0]     x_r;
  logic [ppa_pkg::POS_W-1:0]     y_r;
  logic [ppa_pkg::ADDR_W-1:0]    addr_r;
  logic [ppa_pkg::SAMPLE_W-1:0]  samp_r [ppa_pkg::NUM_CH];
  logic [ppa_pkg::SUM_W-1:0]     sums_r [ppa_pkg::NUM_CH];
  logic [ppa_pkg::BYTE_W-1:0]    bytes_r [ppa_pkg::NUM_CH];
  logic [ppa_pkg::IDX_W-1:0]     pix_r;
  logic [ppa_pkg::IDX_W-1:0]     out_pix_r;
  logic [ppa_pkg::BYTE_W-1:0]    out_bytes_r [ppa_pkg::NUM_CH];

  // Sum store
  logic [MEM_W-1:0]           mem [ppa_pkg::STORE_DEPTH];
  logic [MEM_W-1:0]           rdata_r;
  logic                       mem_we;
  logic [ppa_pkg::ADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]           mem_wdata;

  // Combinational helpers
  logic                      in_hit;
  logic                      in_bounds;
  logic [ppa_pkg::DIM_W-1:0] w_eff;
  logic [ppa_pkg::DIM_W-1:0] h_eff;
  logic [ppa_pkg::CNT_W-1:0] cnt_eff;
  logic [ppa_pkg::C_W-1:0]   c_val;
  logic [ppa_pkg::SUM_W-1:0] new_sum [ppa_pkg::NUM_CH];
  logic [ppa_pkg::IDX_W-1:0] pix_calc;
  logic [ppa_pkg::SUM_W-1:0] cur_sum;
  logic                      cur_pos;
  logic                      cur_full;
  logic [ppa_pkg::C_W-1:0]   s_lo;
  logic                      byte_wr;
  logic [ppa_pkg::BYTE_W-1:0] byte_val;
  logic                      out_load;

  ppa_pkg::div_req_t div_req;
  ppa_pkg::div_rsp_t div_rsp;

  // Effective dimensions and divisor
  always_comb begin
    if (width_r == '0) begin
      w_eff = (ppa_pkg::DIM_W)'(1);
    end else if (width_r > (ppa_pkg::DIM_W)'(ppa_pkg::MAX_WIDTH)) begin
      w_eff = (ppa_pkg::DIM_W)'(ppa_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = (ppa_pkg::DIM_W)'(1);
    end else if (height_r > (ppa_pkg::DIM_W)'(ppa_pkg::MAX_HEIGHT)) begin
      h_eff = (ppa_pkg::DIM_W)'(ppa_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    cnt_eff = (sample_count_r == '0) ? (ppa_pkg::CNT_W)'(1) : sample_count_r;
    c_val   = {cnt_eff, {ppa_pkg::FRAC_BITS{1'b0}}};
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_hit    = in_valid && !in_stall;
  assign in_bounds = ((ppa_pkg::DIM_W)'(in_pos_x) < w_eff) &&
                     ((ppa_pkg::DIM_W)'(in_pos_y) < h_eff);

  // Saturating add or overwrite for each channel
  always_comb begin
    logic [ppa_pkg::SUM_W:0]   ext_sum;
    logic [ppa_pkg::SUM_W-1:0] old_sum;
    logic [ppa_pkg::SUM_W-1:0] ext_samp;
    for (int i = 0; i < ppa_pkg::NUM_CH; i++) begin
      old_sum  = rdata_r[i*ppa_pkg::SUM_W +: ppa_pkg::SUM_W];
      ext_samp = {{(ppa_pkg::SUM_W - ppa_pkg::SAMPLE_W){samp_r[i][ppa_pkg::SAMPLE_W-1]}},
                  samp_r[i]};
      ext_sum  = {old_sum[ppa_pkg::SUM_W-1], old_sum} +
                 {ext_samp[ppa_pkg::SUM_W-1], ext_samp};
      if (op_r != ppa_pkg::OP_ACC) begin
        new_sum[i] = ext_samp;
      end else if (ext_sum[ppa_pkg::SUM_W] != ext_sum[ppa_pkg::SUM_W-1]) begin
        new_sum[i] = ext_sum[ppa_pkg::SUM_W] ? {1'b1, {(ppa_pkg::SUM_W-1){1'b0}}}
                                             : {1'b0, {(ppa_pkg::SUM_W-1){1'b1}}};
      end else begin
        new_sum[i] = ext_sum[ppa_pkg::SUM_W-1:0];
      end
    end
  end

  // Row-flipped display index
  always_comb begin
    logic [ppa_pkg::DIM_W-1:0]   flip_row;
    logic [2*ppa_pkg::DIM_W-1:0] prod;
    flip_row = h_eff - (ppa_pkg::DIM_W)'(1) - (ppa_pkg::DIM_W)'(y_r);
    prod     = flip_row * w_eff + (2*ppa_pkg::DIM_W)'(x_r);
    pix_calc = prod[ppa_pkg::IDX_W-1:0];
  end

  // Per-channel byte setup: saturate directly or feed the divider
  always_comb begin
    logic [ppa_pkg::NUM_W-1:0] s_ext;
    logic [ppa_pkg::NUM_W-1:0] c_ext;
    cur_sum  = sums_r[ch_r];
    cur_pos  = !cur_sum[ppa_pkg::SUM_W-1] && (cur_sum != '0);
    cur_full = (cur_sum >= (ppa_pkg::SUM_W)'(c_val));
    s_lo     = cur_sum[ppa_pkg::C_W-1:0];
    s_ext    = (ppa_pkg::NUM_W)'(s_lo);
    c_ext    = (ppa_pkg::NUM_W)'(c_val);
    div_req.start = (state_r == ST_PREP) && cur_pos && !cur_full;
    if (op_r == ppa_pkg::OP_ACC) begin
      // 510*S + C over 2*C rounds half up
      div_req.num = (s_ext << 9) - (s_ext << 1) + c_ext;
      div_req.den = {c_val, 1'b0};
    end else begin
      // 255*S over C truncates
      div_req.num = (s_ext << 8) - s_ext;
      div_req.den = (ppa_pkg::DEN_W)'(c_val);
    end
  end

  ppa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Byte result of the current channel
  always_comb begin
    byte_wr  = 1'b0;
    byte_val = '0;
    if (state_r == ST_PREP && !cur_pos) begin
      byte_wr = 1'b1;
    end else if (state_r == ST_PREP && cur_full) begin
      byte_wr  = 1'b1;
      byte_val = ppa_pkg::BYTE_MAX;
    end else if (state_r == ST_DIV && div_rsp.done) begin
      byte_wr  = 1'b1;
      byte_val = div_rsp.quo;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ppa_pkg::ADDR_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_hit) begin
          if (in_op == ppa_pkg::OP_CLEAR) begin
            clr_cnt_nxt = '0;
            state_nxt   = ST_CLEAR;
          end else if ((in_op == ppa_pkg::OP_ACC || in_op == ppa_pkg::OP_SET) &&
                       in_bounds) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ch_nxt    = '0;
        state_nxt = ST_PREP;
      end
      ST_PREP, ST_DIV: begin
        if (div_req.start) begin
          state_nxt = ST_DIV;
        end else if (byte_wr) begin
          if (ch_r == (ppa_pkg::CH_W)'(ppa_pkg::NUM_CH - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= (ppa_pkg::CNT_W)'(1);
      width_r        <= (ppa_pkg::DIM_W)'(ppa_pkg::MAX_WIDTH);
      height_r       <= (ppa_pkg::DIM_W)'(ppa_pkg::MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppa_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data;
        ppa_pkg::CFG_WIDTH:        width_r        <= cfg_data[ppa_pkg::DIM_W-1:0];
        ppa_pkg::CFG_HEIGHT:       height_r       <= cfg_data[ppa_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the item, the updated sums, bytes and the result
  always_ff @(posedge clk) begin
    if (in_hit) begin
      op_r      <= in_op;
      x_r       <= in_pos_x;
      y_r       <= in_pos_y;
      addr_r    <= (ppa_pkg::ADDR_W)'(32'(in_pos_y) * ppa_pkg::MAX_WIDTH + 32'(in_pos_x));
      samp_r[0] <= in_red_in;
      samp_r[1] <= in_green_in;
      samp_r[2] <= in_blue_in;
    end
    if (state_r == ST_UPD) begin
      for (int i = 0; i < ppa_pkg::NUM_CH; i++) begin
        sums_r[i] <= new_sum[i];
      end
      pix_r <= pix_calc;
    end
    if (byte_wr) begin
      bytes_r[ch_r] <= byte_val;
    end
    if (out_load) begin
      out_pix_r <= pix_r;
      for (int i = 0; i < ppa_pkg::NUM_CH; i++) begin
        out_bytes_r[i] <= bytes_r[i];
      end
    end
  end

  // Store write port: clearing sweep or sum update
  always_comb begin
    mem_we    = (state_r == ST_CLEAR) || (state_r == ST_UPD);
    mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
    mem_wdata = '0;
    if (state_r == ST_UPD) begin
      mem_wdata = {new_sum[2], new_sum[1], new_sum[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pix_r;
  assign out_red_byte    = out_bytes_r[0];
  assign out_green_byte  = out_bytes_r[1];
  assign out_blue_byte   = out_bytes_r[2];

endmodule

// File: rtl/ppa_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ppa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ppa_pkg::div_req_t req,
  output ppa_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [ppa_pkg::STEP_W-1:0] step_r;
  logic [ppa_pkg::NUM_W-1:0]  rem_r;
  logic [ppa_pkg::NUM_W-1:0]  dsh_r;
  logic [ppa_pkg::QUO_W-1:0]  quo_r;
  logic                       fits;
  logic                       last_step;

  // Compare the remainder with the shifted divisor
  assign fits      = (rem_r >= dsh_r);
  assign last_step = (step_r == (ppa_pkg::STEP_W)'(ppa_pkg::QUO_W - 1));

  // Control: run QUO_W steps after start, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !req.start && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: subtract when the divisor fits, shift in the quotient bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsh_r <= (ppa_pkg::NUM_W)'(req.den) << (ppa_pkg::QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_r - dsh_r) : rem_r;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[ppa_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/ppa_checker.sv
// Port-level checker for the pixel accumulator, bound to the top level.
`include "progressive_pixel_accumulator_core_assert.svh"

module ppa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ppa_pkg::IDX_W-1:0]     out_pixel_index,
  input logic [ppa_pkg::BYTE_W-1:0]    out_red_byte,
  input logic [ppa_pkg::BYTE_W-1:0]    out_green_byte,
  input logic [ppa_pkg::BYTE_W-1:0]    out_blue_byte,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // Hold a stalled result
  `PPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_pixel_index) && $stable(out_red_byte) &&
    $stable(out_green_byte) && $stable(out_blue_byte))

  // Take configuration writes at any time
  `PPA_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

  // Raise a new result only at the end of a busy stretch
  `PPA_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(in_stall))

  // Stall the input and show no result right after reset
  `PPA_ASSERT_NOW(a_reset_sweep, $past(!rst_n), in_stall && !out_valid)

endmodule

bind progressive_pixel_accumulator_core ppa_checker u_ppa_checker (.*);

// File: bench/progressive_pixel_accumulator_core_tb.sv
// Self-checking testbench for the progressive pixel accumulator core.
`timescale 1ns / 100ps

module progressive_pixel_accumulator_core_tb;

  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam int         CLK_HALF  = 10;
  localparam int         RUN_LIMIT = 2_000_000;
  localparam int         SETTLE    = 64;
  localparam int         HOLD_LEN  = 400;
  localparam int         HOLD_AT   = 150;
  localparam int         MAX_SHOWN = 10;
  localparam longint     SUM_HI    = 64'sh7FFF_FFFF;
  localparam longint     SUM_LO    = -64'sh8000_0000;

  typedef struct {
    logic [1:0]                          op;
    logic [ppa_pkg::POS_W-1:0]           x;
    logic [ppa_pkg::POS_W-1:0]           y;
    logic signed [ppa_pkg::SAMPLE_W-1:0] r;
    logic signed [ppa_pkg::SAMPLE_W-1:0] g;
    logic signed [ppa_pkg::SAMPLE_W-1:0] b;
  } pix_item_t;

  typedef struct {
    logic [ppa_pkg::IDX_W-1:0]  idx;
    logic [ppa_pkg::BYTE_W-1:0] r;
    logic [ppa_pkg::BYTE_W-1:0] g;
    logic [ppa_pkg::BYTE_W-1:0] b;
  } pix_result_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          in_op = ppa_pkg::OP_ACC;
  logic [ppa_pkg::POS_W-1:0]           in_pos_x = '0;
  logic [ppa_pkg::POS_W-1:0]           in_pos_y = '0;
  logic signed [ppa_pkg::SAMPLE_W-1:0] in_red_in = '0;
  logic signed [ppa_pkg::SAMPLE_W-1:0] in_green_in = '0;
  logic signed [ppa_pkg::SAMPLE_W-1:0] in_blue_in = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [ppa_pkg::IDX_W-1:0]           out_pixel_index;
  logic [ppa_pkg::BYTE_W-1:0]          out_red_byte;
  logic [ppa_pkg::BYTE_W-1:0]          out_green_byte;
  logic [ppa_pkg::BYTE_W-1:0]          out_blue_byte;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ppa_pkg::CFG_IDX_W-1:0]       cfg_index = ppa_pkg::CFG_SAMPLE_COUNT;
  logic [ppa_pkg::CFG_DAT_W-1:0]       cfg_data = '0;

  // Mirror of the block's registers and sum store
  logic [ppa_pkg::CNT_W-1:0] model_count = 16'd1;
  logic [ppa_pkg::DIM_W-1:0] model_width = 9'd256;
  logic [ppa_pkg::DIM_W-1:0] model_height = 9'd256;
  int                        red_sums   [ppa_pkg::STORE_DEPTH];
  int                        green_sums [ppa_pkg::STORE_DEPTH];
  int                        blue_sums  [ppa_pkg::STORE_DEPTH];

  pix_item_t   pending_items[$];
  pix_result_t expected_pixels[$];

  bit  idle_en = 1'b1;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  progressive_pixel_accumulator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_red_byte    (out_red_byte),
    .out_green_byte  (out_green_byte),
    .out_blue_byte   (out_blue_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Clamp a width or height register to the usable range
  function automatic int unsigned dim_eff(input logic [ppa_pkg::DIM_W-1:0] v,
                                          input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int sat_add(input int sum,
                                 input logic signed [ppa_pkg::SAMPLE_W-1:0] smp);
    longint t;
    t = longint'(sum) + longint'(smp);
    if (t > SUM_HI) t = SUM_HI;
    if (t < SUM_LO) t = SUM_LO;
    return int'(t);
  endfunction

  // Normalize one sum to a display byte
  function automatic logic [ppa_pkg::BYTE_W-1:0] to_display(input int s, input bit rounded);
    longint unsigned c, us;
    c = (model_count == 0) ? 64'd4096 : longint'(model_count) * 4096;
    if (s <= 0) return '0;
    us = longint'(s);
    if (us >= c) return ppa_pkg::BYTE_MAX;
    if (rounded) return (ppa_pkg::BYTE_W)'((510 * us + c) / (2 * c));
    return (ppa_pkg::BYTE_W)'((255 * us) / c);
  endfunction

  // Update the sum store for one accepted item and queue its result, if any
  function automatic void apply_pixel_op(input pix_item_t it);
    int unsigned w, h, a;
    pix_result_t res;
    w = dim_eff(model_width, ppa_pkg::MAX_WIDTH);
    h = dim_eff(model_height, ppa_pkg::MAX_HEIGHT);
    if (it.op == ppa_pkg::OP_CLEAR) begin
      foreach (red_sums[i]) begin
        red_sums[i] = 0;
        green_sums[i] = 0;
        blue_sums[i] = 0;
      end
      return;
    end
    if (it.op != ppa_pkg::OP_ACC && it.op != ppa_pkg::OP_SET) return;
    if (it.x >= w || it.y >= h) return;
    a = it.y * ppa_pkg::MAX_WIDTH + it.x;
    if (it.op == ppa_pkg::OP_ACC) begin
      red_sums[a]   = sat_add(red_sums[a], it.r);
      green_sums[a] = sat_add(green_sums[a], it.g);
      blue_sums[a]  = sat_add(blue_sums[a], it.b);
    end else begin
      red_sums[a]   = it.r;
      green_sums[a] = it.g;
      blue_sums[a]  = it.b;
    end
    res.idx = (ppa_pkg::IDX_W)'((h - 1 - it.y) * w + it.x);
    res.r   = to_display(red_sums[a], it.op == ppa_pkg::OP_ACC);
    res.g   = to_display(green_sums[a], it.op == ppa_pkg::OP_ACC);
    res.b   = to_display(blue_sums[a], it.op == ppa_pkg::OP_ACC);
    expected_pixels.push_back(res);
  endfunction

  // Drive items from the pending queue, with random gaps between them while idle_en is set
  always @(posedge clk) begin : drive_items
    pix_item_t nxt;
    pix_item_t seen;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        seen.op = in_op;
        seen.x  = in_pos_x;
        seen.y  = in_pos_y;
        seen.r  = in_red_in;
        seen.g  = in_green_in;
        seen.b  = in_blue_in;
        apply_pixel_op(seen);
      end
      if (in_valid && !in_fire) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_op       <= nxt.op;
        in_pos_x    <= nxt.x;
        in_pos_y    <= nxt.y;
        in_red_in   <= nxt.r;
        in_green_in <= nxt.g;
        in_blue_in  <= nxt.b;
        in_valid    <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts while idle_en is set, and one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n && out_fire) begin
      results_seen <= results_seen + 1;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected pixel result idx=%0d rgb=%0d,%0d,%0d",
                   out_pixel_index, out_red_byte, out_green_byte, out_blue_byte);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_index !== want.idx || out_red_byte !== want.r ||
            out_green_byte !== want.g || out_blue_byte !== want.b) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"pixel mismatch: expected idx=%0d rgb=%0d,%0d,%0d",
                      " got idx=%0d rgb=%0d,%0d,%0d"},
                     want.idx, want.r, want.g, want.b, out_pixel_index,
                     out_red_byte, out_green_byte, out_blue_byte);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("progressive_pixel_accumulator_core_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [ppa_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (ppa_pkg::CFG_DAT_W)'(val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      ppa_pkg::CFG_SAMPLE_COUNT: model_count  = (ppa_pkg::CNT_W)'(val);
      ppa_pkg::CFG_WIDTH:        model_width  = (ppa_pkg::DIM_W)'(val);
      ppa_pkg::CFG_HEIGHT:       model_height = (ppa_pkg::DIM_W)'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned cnt, input int unsigned w, input int unsigned h);
    write_reg(ppa_pkg::CFG_SAMPLE_COUNT, cnt);
    write_reg(ppa_pkg::CFG_WIDTH, w);
    write_reg(ppa_pkg::CFG_HEIGHT, h);
  endtask

  // Wait until every result is in and any clear sweep is over
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic queue_item(input logic [1:0] op, input int unsigned x, input int unsigned y,
                            input logic signed [ppa_pkg::SAMPLE_W-1:0] r,
                            input logic signed [ppa_pkg::SAMPLE_W-1:0] g,
                            input logic signed [ppa_pkg::SAMPLE_W-1:0] b);
    pix_item_t it;
    it.op = op;
    it.x  = (ppa_pkg::POS_W)'(x);
    it.y  = (ppa_pkg::POS_W)'(y);
    it.r  = r;
    it.g  = g;
    it.b  = b;
    pending_items.push_back(it);
  endtask

  // Sample scaled so a few accumulations land mid-range for the current count
  function automatic logic signed [ppa_pkg::SAMPLE_W-1:0] sample_value();
    int unsigned span, kind;
    span = ((model_count == 0) ? 1 : model_count) * 2048;
    if (span > 32767) span = 32767;
    kind = $urandom_range(0, 7);
    if (kind == 0) return (ppa_pkg::SAMPLE_W)'($urandom);
    if (kind == 1) return -(ppa_pkg::SAMPLE_W)'($urandom_range(0, 4096));
    return (ppa_pkg::SAMPLE_W)'($urandom_range(0, span));
  endfunction

  function automatic pix_item_t random_item(input int unsigned w, input int unsigned h);
    pix_item_t   it;
    int unsigned pick, hot_w, hot_h;
    pick  = $urandom_range(0, 99);
    it.op = pick[0] ? ppa_pkg::OP_SET : ppa_pkg::OP_ACC;
    it.x  = (ppa_pkg::POS_W)'($urandom);
    it.y  = (ppa_pkg::POS_W)'($urandom);
    it.r  = (ppa_pkg::SAMPLE_W)'($urandom);
    it.g  = (ppa_pkg::SAMPLE_W)'($urandom);
    it.b  = (ppa_pkg::SAMPLE_W)'($urandom);
    // noise: unused op code and pixels outside the image
    if (pick < 3) begin
      it.op = OP_NONE;
      return it;
    end
    if (pick < 9 && w < ppa_pkg::MAX_WIDTH) begin
      it.x = (ppa_pkg::POS_W)'($urandom_range(w, ppa_pkg::MAX_WIDTH - 1));
      return it;
    end
    if (pick < 9 && h < ppa_pkg::MAX_HEIGHT) begin
      it.y = (ppa_pkg::POS_W)'($urandom_range(h, ppa_pkg::MAX_HEIGHT - 1));
      return it;
    end
    it.op = (pick < 34) ? ppa_pkg::OP_SET : ppa_pkg::OP_ACC;
    if (pick % 4 == 0) begin
      it.x = (ppa_pkg::POS_W)'($urandom_range(0, w - 1));
      it.y = (ppa_pkg::POS_W)'($urandom_range(0, h - 1));
    end else begin
      // keep most traffic on a few pixels so sums build up
      hot_w = (w < 4) ? w : 4;
      hot_h = (h < 4) ? h : 4;
      it.x = (ppa_pkg::POS_W)'($urandom_range(0, hot_w - 1));
      it.y = (ppa_pkg::POS_W)'($urandom_range(0, hot_h - 1));
    end
    it.r = sample_value();
    it.g = sample_value();
    it.b = sample_value();
    return it;
  endfunction

  task automatic random_phase(input int unsigned cnt, input int unsigned w_reg,
                              input int unsigned h_reg, input int unsigned n_results,
                              input bit with_clear);
    int unsigned produced, w, h;
    pix_item_t   it;
    set_config(cnt, w_reg, h_reg);
    w = dim_eff(model_width, ppa_pkg::MAX_WIDTH);
    h = dim_eff(model_height, ppa_pkg::MAX_HEIGHT);
    produced = 0;
    while (produced < n_results) begin
      it = random_item(w, h);
      if ((it.op == ppa_pkg::OP_ACC || it.op == ppa_pkg::OP_SET) && it.x < w && it.y < h)
        produced++;
      pending_items.push_back(it);
      if (with_clear && produced == n_results / 2) begin
        queue_item(ppa_pkg::OP_CLEAR, $urandom, $urandom,
                   (ppa_pkg::SAMPLE_W)'($urandom), (ppa_pkg::SAMPLE_W)'($urandom),
                   (ppa_pkg::SAMPLE_W)'($urandom));
        with_clear = 1'b0;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    // Full image, unit count: byte extremes, rounding, unused op, clear
    set_config(1, 256, 256);
    queue_item(ppa_pkg::OP_SET, 0, 0, 16'sd4096, 16'sd0, -16'sd1);
    queue_item(ppa_pkg::OP_SET, 255, 255, 16'sh7FFF, 16'sh8000, 16'sd2048);
    queue_item(ppa_pkg::OP_ACC, 255, 255, 16'sh8000, 16'sh7FFF, 16'sd2048);
    queue_item(ppa_pkg::OP_ACC, 10, 20, 16'sd2048, 16'sd2047, 16'sd1);
    queue_item(ppa_pkg::OP_ACC, 0, 128, 16'sd0, 16'sd4096, 16'sd4095);
    queue_item(OP_NONE, 255, 255, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_item(ppa_pkg::OP_SET, 128, 1, 16'sh8000, 16'sh7FFF, 16'sd2049);
    queue_item(ppa_pkg::OP_CLEAR, 255, 255, 16'sh7FFF, 16'sh8000, -16'sd1);
    queue_item(ppa_pkg::OP_ACC, 0, 0, 16'sd1, 16'sd1, 16'sd1);
    queue_item(ppa_pkg::OP_ACC, 255, 255, -16'sd1, 16'sd4096, 16'sd2048);
    wait_idle();

    // Zero count and zero width, height above range
    set_config(0, 0, 511);
    queue_item(ppa_pkg::OP_ACC, 0, 255, 16'sd2048, 16'sd1024, 16'sd4095);
    queue_item(ppa_pkg::OP_SET, 0, 0, 16'sd3000, -16'sd3000, 16'sd4096);
    queue_item(ppa_pkg::OP_ACC, 1, 0, 16'sd100, 16'sd100, 16'sd100);
    queue_item(ppa_pkg::OP_ACC, 255, 5, 16'sd100, 16'sd100, 16'sd100);
    queue_item(ppa_pkg::OP_ACC, 0, 3, 16'sd1000, 16'sd2000, 16'sd3000);
    queue_item(ppa_pkg::OP_ACC, 0, 3, 16'sd1000, 16'sd2000, 16'sd3000);
    wait_idle();

    // Largest count, width above range, zero height
    set_config(65535, 300, 0);
    queue_item(ppa_pkg::OP_ACC, 255, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_item(ppa_pkg::OP_ACC, 255, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_item(ppa_pkg::OP_ACC, 255, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_item(ppa_pkg::OP_SET, 170, 0, 16'sh7FFF, 16'sd1, 16'sh8000);
    queue_item(ppa_pkg::OP_ACC, 85, 1, 16'sd100, 16'sd100, 16'sd100);
    wait_idle();

    // Random traffic over several settings, no idling in the last one
    random_phase(1, 256, 256, 350, 1'b0);
    random_phase(4, 16, 16, 350, 1'b1);
    random_phase(7, 100, 37, 300, 1'b0);
    random_phase(65535, 256, 256, 200, 1'b0);
    random_phase(2, 1, 1, 200, 1'b0);
    idle_en = 1'b0;
    random_phase(3, 256, 256, 600, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (expected_pixels.size() != 0)
      $display("%0d pixel results never arrived", expected_pixels.size());
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("progressive_pixel_accumulator_core_tb: PASS");
    end else begin
      $display("progressive_pixel_accumulator_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: progressive_pixel_accumulator_core.f
+incdir+rtl
rtl/ppa_pkg.sv
rtl/ppa_div.sv
rtl/progressive_pixel_accumulator_core.sv
rtl/ppa_checker.sv
bench/progressive_pixel_accumulator_core_tb.sv
